[hdl/npm_pkg.sv]
// Shared types and constants for the nearest plane matcher.
`timescale 1ns / 1ps

package npm_pkg;

    // Configuration register indexes.
    localparam logic CFG_DIST_THR = 1'b0;
    localparam logic CFG_COS_THR  = 1'b1;

    localparam logic [30:0] DIST_THR_RESET = 31'd3277;
    localparam logic [16:0] COS_THR_RESET  = 17'd65209;
    localparam logic [16:0] COS_ONE        = 17'd65536;

    // Request kinds carried in tuser.
    localparam logic REQ_REFERENCE = 1'b0;
    localparam logic REQ_CANDIDATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DOT,
        ST_DECIDE,
        ST_STORE,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

[hdl/nearest_plane_matcher_top.sv]
// Top level of the nearest plane matcher: sequencer, multiplier and search state.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// s_        in         s_tvalid / s_tready     s_tdata planes+tag, s_tuser kind, s_tlast
// m_        out        m_tvalid / m_tready     m_tdata index+cosine, m_tuser found
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A reference item is accepted, then its normal components are squared and summed, and a
// square root and four divisions run in the one shared root/divide unit before the
// next acceptance. An evaluated candidate adds the dot product, a decision and a
// finish state, a skipped one goes straight to the finish state, and a plane with a
// zero normal stops after the root; a candidate that closes the search adds an emit state.
// s_tready is high only while the sequencer is idle. A result waits in the output
// register; a further result stalls the sequencer until the first is taken.
// Reset (aresetn low, synchronous) clears the reference plane, the search and the
// thresholds to their defaults; no clearing pass is needed.
module nearest_plane_matcher_top #(
    parameter int MAX_CANDIDATES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // coef_a[31:0], coef_b[63:32], coef_c[95:64], coef_d[127:96], frame_tag[143:128]
    input  logic [143:0]  s_tdata,
    // req_type
    input  logic          s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // match_index[7:0], best_cosine[24:8], zero fill[31:25]
    output logic [31:0]   m_tdata,
    // found
    output logic          m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [30:0]   cfg_data
);

    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CANDIDATES);

    npm_pkg::state_t state_reg, state_next;

    logic [1:0]          cnt_reg;
    logic [31:0]         mag_reg [4];       // |a|, |b|, |c|, |d|
    logic [2:0]          sgn_reg;
    logic [15:0]         tag_reg;
    logic                type_reg;
    logic                last_reg;
    logic                deg_reg;
    logic signed [65:0]  acc_reg;
    logic signed [65:0]  prod_reg;
    logic [31:0]         norm_reg;
    logic signed [17:0]  nrm_reg [3];
    logic [31:0]         off_reg;

    logic signed [17:0]  ref_n_reg [3];
    logic [31:0]         ref_off_reg;
    logic [15:0]         ref_tag_reg;
    logic                ref_valid_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       best_idx_reg;
    logic [16:0]         best_dot_reg;
    logic                any_reg;
    logic [30:0]         dist_thr_reg;
    logic [16:0]         cos_thr_reg;

    logic                m_valid_reg;
    logic [31:0]         m_data_reg;
    logic                m_found_reg;

    npm_pkg::unit_req_t  unit_req;
    npm_pkg::unit_rsp_t  unit_rsp;
    logic [63:0]         unit_operand;
    logic [63:0]         unit_result;

    logic                accept;
    logic signed [32:0]  mul_a, mul_b;
    logic [31:0]         div_mag;
    logic [47:0]         quot;
    logic [16:0]         q_norm;
    logic [31:0]         q_off;
    logic [31:0]         off_diff;
    logic [65:0]         dot_mag;
    logic [49:0]         dot_shift;
    logic [16:0]         dot_abs;
    logic                cand_pass;
    logic                out_free;
    logic [CW+7:0]       idx_ext;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Operand selection for the single multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == npm_pkg::ST_SQ) begin
            mul_a = {1'b0, mag_reg[cnt_reg]};
            mul_b = {1'b0, mag_reg[cnt_reg]};
        end else if (cnt_reg != 2'd3) begin
            mul_a = 33'(nrm_reg[cnt_reg]);
            mul_b = 33'(ref_n_reg[cnt_reg]);
        end
    end

    assign div_mag      = mag_reg[cnt_reg];
    assign unit_operand = (state_reg == npm_pkg::ST_SQRT_GO) ? 64'(acc_reg)
                                                             : {16'd0, div_mag, 16'd0};
    assign quot   = unit_result[47:0];
    assign q_norm = (quot > 48'(npm_pkg::COS_ONE)) ? npm_pkg::COS_ONE : quot[16:0];
    assign q_off  = (quot > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];

    assign off_diff  = (off_reg > ref_off_reg) ? off_reg - ref_off_reg
                                               : ref_off_reg - off_reg;
    assign dot_mag   = acc_reg[65] ? 66'(-acc_reg) : 66'(acc_reg);
    assign dot_shift = dot_mag[65:16];
    assign dot_abs   = (dot_shift > 50'(npm_pkg::COS_ONE)) ? npm_pkg::COS_ONE
                                                            : dot_shift[16:0];
    assign cand_pass = ({1'b0, off_diff} <= {2'b0, dist_thr_reg})
                       && (dot_abs >= cos_thr_reg)
                       && (!any_reg || dot_abs > best_dot_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == npm_pkg::REQ_REFERENCE) begin
                        state_next = npm_pkg::ST_SQ;
                    end else if (count_reg < MAX_COUNT && ref_valid_reg
                                 && s_tdata[143:128] == ref_tag_reg) begin
                        state_next = npm_pkg::ST_SQ;
                    end else begin
                        state_next = npm_pkg::ST_FIN;
                    end
                end
            end
            npm_pkg::ST_SQ: begin
                if (cnt_reg == 2'd3) state_next = npm_pkg::ST_SQRT_GO;
            end
            npm_pkg::ST_SQRT_GO:   state_next = npm_pkg::ST_SQRT_WAIT;
            npm_pkg::ST_SQRT_WAIT: begin
                if (unit_rsp.done) begin
                    if (unit_result[31:0] != 32'd0) begin
                        state_next = npm_pkg::ST_DIV_GO;
                    end else if (type_reg == npm_pkg::REQ_REFERENCE) begin
                        state_next = npm_pkg::ST_STORE;
                    end else begin
                        state_next = npm_pkg::ST_FIN;
                    end
                end
            end
            npm_pkg::ST_DIV_GO:    state_next = npm_pkg::ST_DIV_WAIT;
            npm_pkg::ST_DIV_WAIT: begin
                if (unit_rsp.done) begin
                    if (cnt_reg != 2'd3) begin
                        state_next = npm_pkg::ST_DIV_GO;
                    end else if (type_reg == npm_pkg::REQ_REFERENCE) begin
                        state_next = npm_pkg::ST_STORE;
                    end else begin
                        state_next = npm_pkg::ST_DOT;
                    end
                end
            end
            npm_pkg::ST_DOT: begin
                if (cnt_reg == 2'd3) state_next = npm_pkg::ST_DECIDE;
            end
            npm_pkg::ST_DECIDE: state_next = npm_pkg::ST_FIN;
            npm_pkg::ST_STORE:  state_next = npm_pkg::ST_IDLE;
            npm_pkg::ST_FIN: begin
                state_next = last_reg ? npm_pkg::ST_EMIT : npm_pkg::ST_IDLE;
            end
            npm_pkg::ST_EMIT: begin
                if (out_free) state_next = npm_pkg::ST_IDLE;
            end
            default: state_next = npm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready       = 1'b0;
        unit_req.start = 1'b0;
        unit_req.op    = npm_pkg::OP_DIV;
        case (state_reg)
            npm_pkg::ST_IDLE: s_tready = 1'b1;
            npm_pkg::ST_SQRT_GO: begin
                unit_req.start = 1'b1;
                unit_req.op    = npm_pkg::OP_SQRT;
            end
            npm_pkg::ST_DIV_GO: unit_req.start = 1'b1;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    npm_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .operand (unit_operand),
        .divisor (norm_reg),
        .rsp     (unit_rsp),
        .result  (unit_result)
    );

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            npm_pkg::ST_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < 4; i++) begin
                        mag_reg[i] <= s_tdata[32*i+31] ? 32'(-s_tdata[32*i +: 32])
                                                       : s_tdata[32*i +: 32];
                    end
                    sgn_reg  <= {s_tdata[95], s_tdata[63], s_tdata[31]};
                    tag_reg  <= s_tdata[143:128];
                    type_reg <= s_tuser;
                    last_reg <= s_tlast && (s_tuser == npm_pkg::REQ_CANDIDATE);
                    idx_reg  <= count_reg;
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    deg_reg  <= 1'b0;
                end
            end
            npm_pkg::ST_SQ: begin
                if (cnt_reg != 2'd0) acc_reg <= acc_reg + prod_reg;
                cnt_reg <= cnt_reg + 2'd1;
            end
            npm_pkg::ST_SQRT_WAIT: begin
                if (unit_rsp.done) begin
                    norm_reg <= unit_result[31:0];
                    cnt_reg  <= '0;
                    if (unit_result[31:0] == 32'd0) begin
                        deg_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) nrm_reg[i] <= '0;
                        off_reg <= '0;
                    end
                end
            end
            npm_pkg::ST_DIV_WAIT: begin
                if (unit_rsp.done) begin
                    if (cnt_reg != 2'd3) begin
                        nrm_reg[cnt_reg] <= sgn_reg[cnt_reg] ? -18'(q_norm) : 18'(q_norm);
                    end else begin
                        off_reg <= q_off;
                        acc_reg <= '0;
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
            npm_pkg::ST_DOT: begin
                if (cnt_reg != 2'd0) acc_reg <= acc_reg + prod_reg;
                cnt_reg <= cnt_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign idx_ext = {8'd0, best_idx_reg};

    // Reference plane, search state, thresholds and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= npm_pkg::ST_IDLE;
            for (int i = 0; i < 3; i++) ref_n_reg[i] <= '0;
            ref_off_reg   <= '0;
            ref_tag_reg   <= '0;
            ref_valid_reg <= 1'b0;
            count_reg     <= '0;
            best_idx_reg  <= '0;
            best_dot_reg  <= '0;
            any_reg       <= 1'b0;
            dist_thr_reg  <= npm_pkg::DIST_THR_RESET;
            cos_thr_reg   <= npm_pkg::COS_THR_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    npm_pkg::CFG_DIST_THR: dist_thr_reg <= cfg_data;
                    npm_pkg::CFG_COS_THR:  cos_thr_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                npm_pkg::ST_IDLE: begin
                    if (accept && s_tuser == npm_pkg::REQ_CANDIDATE
                        && count_reg < MAX_COUNT) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                npm_pkg::ST_STORE: begin
                    for (int i = 0; i < 3; i++) ref_n_reg[i] <= nrm_reg[i];
                    ref_off_reg   <= off_reg;
                    ref_tag_reg   <= tag_reg;
                    ref_valid_reg <= !deg_reg;
                    count_reg     <= '0;
                    best_idx_reg  <= '0;
                    best_dot_reg  <= '0;
                    any_reg       <= 1'b0;
                end
                npm_pkg::ST_DECIDE: begin
                    if (cand_pass) begin
                        any_reg      <= 1'b1;
                        best_dot_reg <= dot_abs;
                        best_idx_reg <= idx_reg;
                    end
                end
                npm_pkg::ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_found_reg  <= any_reg;
                        m_data_reg   <= any_reg ? {7'd0, best_dot_reg, idx_ext[7:0]} : '0;
                        count_reg    <= '0;
                        best_idx_reg <= '0;
                        best_dot_reg <= '0;
                        any_reg      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

`ifndef SYNTHESIS
    // A result without a match carries a zero index and cosine.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("empty result carries nonzero payload");

    // The shared unit only finishes while the sequencer waits for it.
    a_unit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_rsp.done |-> state_reg == npm_pkg::ST_SQRT_WAIT
                          || state_reg == npm_pkg::ST_DIV_WAIT)
        else $error("root/divide unit finished outside a wait state");

    // The candidate counter saturates at the configured limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("candidate count beyond limit");
`endif

endmodule

[hdl/npm_root_div.sv]
// Shared iterative unit: 64-bit integer square root or 48/32 restoring division.
`timescale 1ns / 1ps

module npm_root_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  npm_pkg::unit_req_t req,
    input  logic [63:0]        operand,
    input  logic [31:0]        divisor,
    output npm_pkg::unit_rsp_t rsp,
    output logic [63:0]        result
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    npm_pkg::unit_op_t  op_reg, op_next;
    logic [63:0]        acc_reg, acc_next;   // sqrt remainder or division remainder
    logic [63:0]        res_reg, res_next;   // root or quotient
    logic [63:0]        bit_reg, bit_next;   // sqrt trial bit or dividend shifter

    logic [63:0] trial;
    logic [32:0] shifted;

    assign trial   = res_reg + bit_reg;
    assign shifted = {acc_reg[31:0], bit_reg[47]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            res_next  = '0;
            if (req.op == npm_pkg::OP_SQRT) begin
                acc_next = operand;
                bit_next = 64'h4000_0000_0000_0000;
            end else begin
                acc_next = '0;
                bit_next = operand;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if (op_reg == npm_pkg::OP_SQRT) begin
                if (acc_reg >= trial) begin
                    acc_next = acc_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == 6'd31) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                if (shifted >= {1'b0, divisor}) begin
                    acc_next = {31'd0, shifted - {1'b0, divisor}};
                    res_next = {res_reg[62:0], 1'b1};
                end else begin
                    acc_next = {31'd0, shifted};
                    res_next = {res_reg[62:0], 1'b0};
                end
                bit_next = {bit_reg[62:0], 1'b0};
                if (cnt_reg == 6'd47) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= npm_pkg::OP_SQRT;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule
